### hdl/arm_pkg.sv
// Shared types, constants and helpers for the axis rotation matrix block.
`timescale 1ns / 1ps
`default_nettype none
package arm_pkg;

  typedef struct packed {
    logic       flip;
    logic [1:0] axis;
  } arm_tag_t;

  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  localparam int TABLE_LEN = 24;

  localparam logic [24:0] FULL_TURN    = 25'd23592960;
  localparam logic [24:0] HALF_TURN    = 25'd11796480;
  localparam logic [24:0] QUARTER_TURN = 25'd5898240;
  localparam logic [24:0] THREE_QTR    = 25'd17694720;

  localparam logic [13:0] TURN_HI_BIAS = 14'd4140;
  localparam logic [24:0] RECIP_45     = 25'd1456;
  localparam logic [13:0] TURNS_45     = 14'd45;

  localparam logic [35:0] DEG_RAD_HI = 36'd4575;
  localparam logic [36:0] DEG_RAD_LO = 37'd4521;
  localparam logic [49:0] DEG_RAD_RND = 50'd131072;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam longint GAIN_Q30 = 64'd652032874;

  localparam longint ATAN_Q30 [TABLE_LEN] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  function automatic longint half_lsb(int s);
    if (s > 0) begin
      return longint'(1) << (s - 1);
    end
    return 0;
  endfunction

  function automatic longint round_q30(longint v, int frac);
    return (v + half_lsb(30 - frac)) >>> (30 - frac);
  endfunction

endpackage
`default_nettype wire

### hdl/arm_angle_reduce.sv
// Angle reduction modulo 360, fold to +/-90 degrees and conversion to radians.
`timescale 1ns / 1ps
`default_nettype none
module arm_angle_reduce #(
  parameter int FRAC = 14,
  parameter int W    = 17
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       en,
  input  wire                       in_valid,
  input  wire  signed [31:0]        in_angle,
  input  wire         [1:0]         in_axis,
  output logic                      out_valid,
  output arm_pkg::arm_tag_t         out_tag,
  output logic signed [W-1:0]       out_z
);
  import arm_pkg::*;

  localparam int     SH   = 30 - FRAC;
  localparam longint ZRND = half_lsb(SH);

  logic [5:0] v_r;

  logic [13:0] u_nxt, u_r;
  logic [24:0] qprod;
  logic [7:0]  q_r;
  logic [18:0] low_r;
  logic [1:0]  ax1_r, ax2_r;

  logic [13:0] t45, rem;
  logic [5:0]  r6;
  logic [24:0] d_nxt, d_r;

  logic        neg_nxt, flip_nxt;
  logic [22:0] mag_nxt, mag_r;
  arm_tag_t    tag3_r, tag4_r, tag5_r, tag6_r;
  logic        neg3_r, neg4_r, neg5_r;

  logic [35:0] ph_r;
  logic [36:0] pl_r;
  logic [49:0] rsum;
  logic [30:0] magq_r;

  logic [31:0] zsum, zm;
  logic signed [W-1:0] z_nxt, z_r;

  always_comb begin
    u_nxt = {in_angle[31], in_angle[31:19]} + TURN_HI_BIAS;
    qprod = 25'(u_nxt) * RECIP_45;
  end

  always_comb begin
    t45 = 14'(q_r) * TURNS_45;
    rem = u_r - t45;
    if (rem[6:0] >= 7'(TURNS_45)) begin
      r6 = 6'(rem[6:0] - 7'(TURNS_45));
    end else begin
      r6 = rem[5:0];
    end
    d_nxt = {r6, low_r};
  end

  always_comb begin
    if (d_r <= QUARTER_TURN) begin
      flip_nxt = 1'b0;
      neg_nxt  = 1'b0;
      mag_nxt  = d_r[22:0];
    end else if (d_r < THREE_QTR) begin
      flip_nxt = 1'b1;
      neg_nxt  = d_r < HALF_TURN;
      mag_nxt  = neg_nxt ? 23'(HALF_TURN - d_r) : 23'(d_r - HALF_TURN);
    end else begin
      flip_nxt = 1'b0;
      neg_nxt  = 1'b1;
      mag_nxt  = 23'(FULL_TURN - d_r);
    end
  end

  always_comb begin
    rsum = {ph_r, 14'b0} + 50'(pl_r) + DEG_RAD_RND;
    zsum = 32'(magq_r) + 32'(ZRND);
    zm   = zsum >> SH;
    z_nxt = neg5_r ? -W'(zm) : W'(zm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= u_nxt;
      q_r    <= qprod[23:16];
      low_r  <= in_angle[18:0];
      ax1_r  <= in_axis;
      d_r    <= d_nxt;
      ax2_r  <= ax1_r;
      mag_r  <= mag_nxt;
      neg3_r <= neg_nxt;
      tag3_r <= '{flip: flip_nxt, axis: ax2_r};
      ph_r   <= 36'(mag_r) * DEG_RAD_HI;
      pl_r   <= 37'(mag_r) * DEG_RAD_LO;
      neg4_r <= neg3_r;
      tag4_r <= tag3_r;
      magq_r <= rsum[48:18];
      neg5_r <= neg4_r;
      tag5_r <= tag4_r;
      z_r    <= z_nxt;
      tag6_r <= tag5_r;
    end
  end

  assign out_valid = v_r[5];
  assign out_tag   = tag6_r;
  assign out_z     = z_r;

endmodule
`default_nettype wire

### hdl/arm_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with its pipeline register.
`timescale 1ns / 1ps
`default_nettype none
module arm_cordic_cell #(
  parameter int IDX  = 0,
  parameter int FRAC = 14,
  parameter int W    = 17
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    in_valid,
  input  arm_pkg::arm_tag_t      in_tag,
  input  wire  signed [W-1:0]    in_x,
  input  wire  signed [W-1:0]    in_y,
  input  wire  signed [W-1:0]    in_z,
  output logic                   out_valid,
  output arm_pkg::arm_tag_t      out_tag,
  output logic signed [W-1:0]    out_x,
  output logic signed [W-1:0]    out_y,
  output logic signed [W-1:0]    out_z
);
  import arm_pkg::*;

  localparam logic signed [W-1:0] ATAN = W'(round_q30(ATAN_Q30[IDX], FRAC));

  logic signed [W-1:0] dx, dy;

  assign dx = in_y >>> IDX;
  assign dy = in_x >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tag <= in_tag;
      if (!in_z[W-1]) begin
        out_x <= in_x - dx;
        out_y <= in_y + dy;
        out_z <= in_z - ATAN;
      end else begin
        out_x <= in_x + dx;
        out_y <= in_y - dy;
        out_z <= in_z + ATAN;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/arm_row_emit.sv
// Rounding to Q1.14 and row-by-row output of the rotation matrix.
`timescale 1ns / 1ps
`default_nettype none
module arm_row_emit #(
  parameter int FRAC = 14,
  parameter int W    = 17
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  arm_pkg::arm_tag_t     in_tag,
  input  wire  signed [W-1:0]   in_x,
  input  wire  signed [W-1:0]   in_y,
  output logic                  adv,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic        [1:0]     out_row_index,
  output logic signed [15:0]    out_col_zero,
  output logic signed [15:0]    out_col_one,
  output logic signed [15:0]    out_col_two,
  output logic signed [15:0]    out_col_three,
  output logic                  out_last_row
);
  import arm_pkg::*;

  localparam int     SHR  = (FRAC > 14) ? FRAC - 14 : 0;
  localparam int     SHL  = (FRAC < 14) ? 14 - FRAC : 0;
  localparam int     MW   = W + SHL;
  localparam longint HALF = half_lsb(SHR);
  localparam logic [MW-1:0] SAT = MW'(16384);

  function automatic logic signed [15:0] to_q14(logic signed [W-1:0] v, logic flip);
    logic [W-1:0]  m;
    logic [MW-1:0] mr;
    logic [15:0]   q;
    m  = v[W-1] ? -v : v;
    mr = ((MW'(m) + MW'(HALF)) >> SHR) << SHL;
    if (mr > SAT) begin
      q = 16'd16384;
    end else begin
      q = mr[15:0];
    end
    return (v[W-1] ^ flip) ? -q : q;
  endfunction

  logic                hold_v_r;
  logic [1:0]          row_r;
  logic [1:0]          axis_r;
  logic signed [15:0]  c_r, s_r, ns;
  logic signed [15:0]  col [4];

  assign adv = !hold_v_r || (out_ready && row_r == ROW_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      row_r    <= '0;
    end else if (adv) begin
      hold_v_r <= in_valid;
      row_r    <= '0;
    end else if (out_ready) begin
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r    <= to_q14(in_x, in_tag.flip);
      s_r    <= to_q14(in_y, in_tag.flip);
      axis_r <= in_tag.axis;
    end
  end

  assign ns = -s_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      col[k] = (2'(k) == row_r) ? ONE_Q14 : 16'sd0;
    end
    case (axis_r)
      AXIS_X: begin
        case (row_r)
          2'd1: begin col[1] = c_r; col[2] = ns; end
          2'd2: begin col[1] = s_r; col[2] = c_r; end
          default: ;
        endcase
      end
      AXIS_Y: begin
        case (row_r)
          2'd0: begin col[0] = c_r; col[2] = s_r; end
          2'd2: begin col[0] = ns; col[2] = c_r; end
          default: ;
        endcase
      end
      AXIS_Z: begin
        case (row_r)
          2'd0: begin col[0] = c_r; col[1] = ns; end
          2'd1: begin col[0] = s_r; col[1] = c_r; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign out_valid     = hold_v_r;
  assign out_row_index = row_r;
  assign out_col_zero  = col[0];
  assign out_col_one   = col[1];
  assign out_col_two   = col[2];
  assign out_col_three = col[3];
  assign out_last_row  = (row_r == ROW_LAST);

endmodule
`default_nettype wire

### hdl/axis_rotation_matrix.sv
// Top level: elementary 4x4 rotation matrix about the X, Y or Z axis.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, in_angle_deg, in_axis | request in
//   out     | out_valid, out_ready, out_row_index,      | request out
//           | out_col_zero..out_col_three, out_last_row |
//
// The first row leaves after the reduction, CORDIC and row registers.
// The row stage sends one matrix row per cycle while out_ready is high.
// Synchronous active-low reset empties every stage.
// out_ready low holds the current row. While a matrix is held, the whole
// pipeline halts until its last row is taken, and in_ready is low meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module axis_rotation_matrix #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRACTION_BITS = 14
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [31:0] in_angle_deg,
  input  wire         [1:0]  in_axis,
  output logic               out_valid,
  input  wire                out_ready,
  output logic        [1:0]  out_row_index,
  output logic signed [15:0] out_col_zero,
  output logic signed [15:0] out_col_one,
  output logic signed [15:0] out_col_two,
  output logic signed [15:0] out_col_three,
  output logic               out_last_row
);
  import arm_pkg::*;

  localparam int W = FRACTION_BITS + 3;
  localparam logic signed [W-1:0] GAIN = W'(round_q30(GAIN_Q30, FRACTION_BITS));

  logic                adv;
  logic                cv   [CORDIC_STAGES+1];
  arm_tag_t            ctag [CORDIC_STAGES+1];
  logic signed [W-1:0] cx   [CORDIC_STAGES+1];
  logic signed [W-1:0] cy   [CORDIC_STAGES+1];
  logic signed [W-1:0] cz   [CORDIC_STAGES+1];

  assign in_ready = adv;
  assign cx[0]    = GAIN;
  assign cy[0]    = '0;

  arm_angle_reduce #(
    .FRAC (FRACTION_BITS),
    .W    (W)
  ) u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .in_angle  (in_angle_deg),
    .in_axis   (in_axis),
    .out_valid (cv[0]),
    .out_tag   (ctag[0]),
    .out_z     (cz[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    arm_cordic_cell #(
      .IDX  (i),
      .FRAC (FRACTION_BITS),
      .W    (W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (cv[i]),
      .in_tag    (ctag[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .out_valid (cv[i+1]),
      .out_tag   (ctag[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1])
    );
  end

  arm_row_emit #(
    .FRAC (FRACTION_BITS),
    .W    (W)
  ) u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (cv[CORDIC_STAGES]),
    .in_tag        (ctag[CORDIC_STAGES]),
    .in_x          (cx[CORDIC_STAGES]),
    .in_y          (cy[CORDIC_STAGES]),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_col_zero  (out_col_zero),
    .out_col_one   (out_col_one),
    .out_col_two   (out_col_two),
    .out_col_three (out_col_three),
    .out_last_row  (out_last_row)
  );

endmodule
`default_nettype wire

### bench/axis_rotation_matrix_checker.sv
// Checker for the rotation matrix block: predicts the four rows of each request and compares.
`timescale 1ns / 1ps
module axis_rotation_matrix_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRACTION_BITS = 14
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire  signed [31:0] in_angle_deg,
  input  wire         [1:0]  in_axis,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire         [1:0]  out_row_index,
  input  wire  signed [15:0] out_col_zero,
  input  wire  signed [15:0] out_col_one,
  input  wire  signed [15:0] out_col_two,
  input  wire  signed [15:0] out_col_three,
  input  wire                out_last_row,
  output int                 fail_count,
  output int                 pending_rows
);
  import arm_pkg::*;

  typedef struct packed {
    logic        [1:0]  row;
    logic signed [15:0] col0;
    logic signed [15:0] col1;
    logic signed [15:0] col2;
    logic signed [15:0] col3;
    logic               last;
  } matrix_row_t;

  localparam longint TURN_Q16      = longint'(FULL_TURN);
  localparam longint HALF_Q16      = longint'(HALF_TURN);
  localparam longint QUARTER_Q16   = longint'(QUARTER_TURN);
  localparam longint unsigned DEG_TO_RAD_Q32 = 64'd74961321;
  localparam int     MAX_REPORTS   = 40;

  matrix_row_t expected_rows[$];
  matrix_row_t want;

  initial begin
    fail_count   = 0;
    pending_rows = 0;
  end

  function automatic longint rescale_frac(longint v, int from_bits, int to_bits);
    logic neg;
    longint unsigned mag;
    int sh;
    neg = v < 0;
    mag = neg ? longint'(0) - v : v;
    sh  = from_bits - to_bits;
    if (sh > 0) begin
      if (sh > 62) mag = 0;
      else mag = (mag + (64'd1 << (sh - 1))) >> sh;
    end else if (sh < 0) begin
      if (-sh > 30) sh = -30;
      mag = mag << (-sh);
    end
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint shift_floor(longint v, int sh);
    if (sh > 62) sh = 62;
    return v >>> sh;
  endfunction

  function automatic longint saturate_q14(longint v);
    longint r;
    r = rescale_frac(v, FRACTION_BITS, 14);
    if (r > longint'(ONE_Q14)) r = longint'(ONE_Q14);
    if (r < -longint'(ONE_Q14)) r = -longint'(ONE_Q14);
    return r;
  endfunction

  task automatic push_rotation_rows(input logic signed [31:0] angle, input logic [1:0] axis);
    longint d, x, y, z, dx, dy, t, c, s;
    longint unsigned mag;
    logic flip, neg;
    int stages;
    logic signed [15:0] m [4][4];
    matrix_row_t row;
    flip = 1'b0;
    d = longint'(angle) % TURN_Q16;
    if (d < 0) d += TURN_Q16;
    if (d >= HALF_Q16) d -= TURN_Q16;
    if (d > QUARTER_Q16) begin
      d -= HALF_Q16;
      flip = 1'b1;
    end else if (d < -QUARTER_Q16) begin
      d += HALF_Q16;
      flip = 1'b1;
    end
    neg = d < 0;
    mag = neg ? -d : d;
    mag = (mag * DEG_TO_RAD_Q32 + (64'd1 << 17)) >> 18;
    z = rescale_frac(neg ? -longint'(mag) : longint'(mag), 30, FRACTION_BITS);
    x = rescale_frac(GAIN_Q30, 30, FRACTION_BITS);
    y = 0;
    stages = CORDIC_STAGES;
    if (stages > TABLE_LEN) stages = TABLE_LEN;
    if (stages < 0) stages = 0;
    for (int i = 0; i < stages; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      t  = rescale_frac(ATAN_Q30[i], 30, FRACTION_BITS);
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= t;
      end else begin
        x += dx;
        y -= dy;
        z += t;
      end
    end
    c = saturate_q14(x);
    s = saturate_q14(y);
    if (flip) begin
      c = -c;
      s = -s;
    end
    for (int r = 0; r < 4; r++) begin
      for (int k = 0; k < 4; k++) begin
        m[r][k] = (r == k) ? ONE_Q14 : 16'sd0;
      end
    end
    case (axis)
      AXIS_X: begin
        m[1][1] = c[15:0];
        m[1][2] = -s[15:0];
        m[2][1] = s[15:0];
        m[2][2] = c[15:0];
      end
      AXIS_Y: begin
        m[0][0] = c[15:0];
        m[0][2] = s[15:0];
        m[2][0] = -s[15:0];
        m[2][2] = c[15:0];
      end
      AXIS_Z: begin
        m[0][0] = c[15:0];
        m[0][1] = -s[15:0];
        m[1][0] = s[15:0];
        m[1][1] = c[15:0];
      end
      default: begin
      end
    endcase
    for (int r = 0; r < 4; r++) begin
      row.row  = 2'(r);
      row.col0 = m[r][0];
      row.col1 = m[r][1];
      row.col2 = m[r][2];
      row.col3 = m[r][3];
      row.last = (2'(r) == ROW_LAST);
      expected_rows.push_back(row);
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    if (fail_count < MAX_REPORTS) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp_val);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          report_mismatch("row with nothing pending, row_index", out_row_index, 0);
        end else begin
          want = expected_rows.pop_front();
          if (out_row_index !== want.row) report_mismatch("row_index", out_row_index, want.row);
          if (out_col_zero !== want.col0) report_mismatch("col_zero", out_col_zero, want.col0);
          if (out_col_one !== want.col1) report_mismatch("col_one", out_col_one, want.col1);
          if (out_col_two !== want.col2) report_mismatch("col_two", out_col_two, want.col2);
          if (out_col_three !== want.col3) report_mismatch("col_three", out_col_three, want.col3);
          if (out_last_row !== want.last) report_mismatch("last_row", out_last_row, want.last);
        end
      end
      if (in_valid && in_ready) begin
        push_rotation_rows(in_angle_deg, in_axis);
      end
      pending_rows <= expected_rows.size();
    end
  end

endmodule

### bench/axis_rotation_matrix_tb.sv
// Top of the rotation matrix testbench: clock, reset, request stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps
module axis_rotation_matrix_tb;
  import arm_pkg::*;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 14;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PER_PHASE = 115;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_angle_deg = '0;
  logic        [1:0]  in_axis = AXIS_X;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic        [1:0]  out_row_index;
  logic signed [15:0] out_col_zero;
  logic signed [15:0] out_col_one;
  logic signed [15:0] out_col_two;
  logic signed [15:0] out_col_three;
  logic               out_last_row;

  int fail_count;
  int pending_rows;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  logic [31:0] directed_angle [14];

  always #1 clk = ~clk;

  axis_rotation_matrix #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_angle_deg (in_angle_deg),
    .in_axis      (in_axis),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row_index(out_row_index),
    .out_col_zero (out_col_zero),
    .out_col_one  (out_col_one),
    .out_col_two  (out_col_two),
    .out_col_three(out_col_three),
    .out_last_row (out_last_row)
  );

  axis_rotation_matrix_checker #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_angle_deg (in_angle_deg),
    .in_axis      (in_axis),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row_index(out_row_index),
    .out_col_zero (out_col_zero),
    .out_col_one  (out_col_one),
    .out_col_two  (out_col_two),
    .out_col_three(out_col_three),
    .out_last_row (out_last_row),
    .fail_count   (fail_count),
    .pending_rows (pending_rows)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_request(input logic [31:0] angle, input logic [1:0] axis);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_angle_deg <= angle;
    in_axis      <= axis;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [31:0] random_angle();
    int k;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return 32'(int'($urandom_range(94371840)) - 47185920);
      default: begin
        k = int'($urandom_range(16)) - 8;
        return 32'(k * int'(QUARTER_TURN) + int'($urandom_range(64)) - 32);
      end
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [1:0] axis;
    for (int n = 0; n < count; n++) begin
      axis = 2'($urandom_range(2));
      if ($urandom_range(15) == 0) axis = 2'($urandom_range(3));
      send_request(random_angle(), axis);
    end
  endtask

  initial begin
    directed_angle[0]  = '0;
    directed_angle[1]  = 32'(QUARTER_TURN);
    directed_angle[2]  = -32'(QUARTER_TURN);
    directed_angle[3]  = 32'(HALF_TURN);
    directed_angle[4]  = -32'(HALF_TURN);
    directed_angle[5]  = 32'(THREE_QTR);
    directed_angle[6]  = 32'(FULL_TURN);
    directed_angle[7]  = 32'(QUARTER_TURN) >> 1;
    directed_angle[8]  = 32'h7FFF_FFFF;
    directed_angle[9]  = 32'h8000_0000;
    directed_angle[10] = 32'(QUARTER_TURN) + 32'd1;
    directed_angle[11] = 32'(HALF_TURN) - 32'd1;
    directed_angle[12] = 32'hFFFF_FFFF;
    directed_angle[13] = -32'(QUARTER_TURN) - 32'd1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 58;
    for (int i = 0; i < 14; i++) begin
      send_request(directed_angle[i], 2'(i));
    end
    for (int i = 0; i < 4; i++) begin
      send_request(32'd1966080, 2'(i));
    end
    send_random(RANDOM_PER_PHASE - 18);

    send_idle_pct = 58;
    recv_idle_pct = 28;
    send_random(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_PER_PHASE);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    repeat (CORDIC_STAGES + 16) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
